// ----- hw/rtl/brc_pkg.sv -----
package brc_pkg;

    // Widths of the interface fields and calibration registers.
    localparam int RAW_W     = 20;
    localparam int OUT_W     = 32;
    localparam int CAL_W     = 48;
    localparam int NUM_CAL   = 4;
    localparam int CFG_IDX_W = 2;

    // Divider geometry: one quotient bit per stage.
    localparam int DIV_W = 64;
    localparam int DEN_W = 31;

    // Register stages before and after the divider.
    localparam int PRE_STAGES  = 12;
    localparam int POST_STAGES = 7;

    // Fixed offsets of the compensation formulas.
    localparam logic signed [23:0] FINE_OFFSET = 24'sd128000;
    localparam logic [20:0]        PRESS_BASE  = 21'd1048576;
    localparam logic [63:0]        V1_BIAS     = 64'h0000_8000_0000_0000;

    // Calibration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CAL_TEMP       = 2'd0,
        CAL_PRESS_LOW  = 2'd1,
        CAL_PRESS_MID  = 2'd2,
        CAL_PRESS_HIGH = 2'd3
    } cal_index_t;

    // Values that ride alongside the division.
    typedef struct packed {
        logic signed [OUT_W-1:0] fine;
        logic signed [OUT_W-1:0] centi;
        logic                    qneg;
        logic                    invalid;
    } brc_side_t;

endpackage

// ----- hw/rtl/barometer_raw_compensation_unit.sv -----
// Channel  | Direction | Handshake          | Payload
// cfg      | in        | cfg_wr_en          | cfg_wr_index, cfg_wr_data
// s        | in        | s_valid / s_ready  | s_raw_temperature, s_raw_pressure
// m        | out       | m_valid / m_ready  | m_fine_temperature, m_temperature_centi,
//          |           |                    | m_pressure_q24_8, m_pressure_invalid
//
// One sample pair enters per cycle, except while the pipeline holds.
// The pipeline has 12 front stages, the 64 one-bit stages of the pressure divider and 7 back stages.
// Reset is synchronous and active low; it clears the valid bits and the calibration registers.
// When m_valid is high and m_ready low, the whole pipeline holds and s_ready is low.
module barometer_raw_compensation_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [brc_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [brc_pkg::CAL_W-1:0]       cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [brc_pkg::RAW_W-1:0]       s_raw_temperature,
    input  logic [brc_pkg::RAW_W-1:0]       s_raw_pressure,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [brc_pkg::OUT_W-1:0] m_fine_temperature,
    output logic signed [brc_pkg::OUT_W-1:0] m_temperature_centi,
    output logic [brc_pkg::OUT_W-1:0]       m_pressure_q24_8,
    output logic                            m_pressure_invalid
);
    import brc_pkg::*;

    // Calibration registers.
    logic [CAL_W-1:0] cal_reg [NUM_CAL];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CAL; i++) begin
                cal_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            cal_reg[cfg_wr_index] <= cfg_wr_data;
        end
    end

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = cal_reg[CAL_TEMP][15:0];
    assign t2 = $signed(cal_reg[CAL_TEMP][31:16]);
    assign t3 = $signed(cal_reg[CAL_TEMP][47:32]);
    assign p1 = cal_reg[CAL_PRESS_LOW][15:0];
    assign p2 = $signed(cal_reg[CAL_PRESS_LOW][31:16]);
    assign p3 = $signed(cal_reg[CAL_PRESS_LOW][47:32]);
    assign p4 = $signed(cal_reg[CAL_PRESS_MID][15:0]);
    assign p5 = $signed(cal_reg[CAL_PRESS_MID][31:16]);
    assign p6 = $signed(cal_reg[CAL_PRESS_MID][47:32]);
    assign p7 = $signed(cal_reg[CAL_PRESS_HIGH][15:0]);
    assign p8 = $signed(cal_reg[CAL_PRESS_HIGH][31:16]);
    assign p9 = $signed(cal_reg[CAL_PRESS_HIGH][47:32]);

    // The pipeline advances as one unit unless a finished result is held.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Valid bits of the stages before and after the divider.
    logic pre_valid_reg  [PRE_STAGES];
    logic post_valid_reg [POST_STAGES];
    logic div_out_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PRE_STAGES; i++) begin
                pre_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < POST_STAGES; i++) begin
                post_valid_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            pre_valid_reg[0] <= s_valid;
            for (int i = 1; i < PRE_STAGES; i++) begin
                pre_valid_reg[i] <= pre_valid_reg[i-1];
            end
            post_valid_reg[0] <= div_out_valid;
            for (int i = 1; i < POST_STAGES; i++) begin
                post_valid_reg[i] <= post_valid_reg[i-1];
            end
        end
    end

    // Stage 1: temperature differences and their first products.
    logic signed [17:0] x1_w;
    logic signed [16:0] dt_w;
    logic signed [33:0] s1_ma_reg, s1_md_reg;
    logic [RAW_W-1:0]   s1_adcp_reg;

    assign x1_w = $signed({1'b0, s_raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign dt_w = $signed({1'b0, s_raw_temperature[19:4]}) - $signed({1'b0, t1});

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ma_reg   <= x1_w * t2;
            s1_md_reg   <= dt_w * dt_w;
            s1_adcp_reg <= s_raw_pressure;
        end
    end

    // Stage 2: first temperature term and the squared term times T3.
    logic signed [31:0] a_w, dd_w;
    logic signed [47:0] mb_w;
    logic signed [31:0] s2_a_reg;
    logic [31:0]        s2_mb_reg;
    logic [RAW_W-1:0]   s2_adcp_reg;

    assign a_w  = $signed(s1_ma_reg[31:0]) >>> 11;
    assign dd_w = $signed(s1_md_reg[31:0]) >>> 12;
    assign mb_w = dd_w * t3;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_a_reg    <= a_w;
            s2_mb_reg   <= mb_w[31:0];
            s2_adcp_reg <= s1_adcp_reg;
        end
    end

    // Stage 3: fine temperature.
    logic signed [31:0] b_w, fine_w;
    logic signed [31:0] s3_fine_reg;
    logic [RAW_W-1:0]   s3_adcp_reg;

    assign b_w    = $signed(s2_mb_reg) >>> 14;
    assign fine_w = s2_a_reg + b_w;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_fine_reg <= fine_w;
            s3_adcp_reg <= s2_adcp_reg;
        end
    end

    // Stage 4: temperature in hundredths, pressure offset variable and inverted raw pressure.
    // The fine temperature always fits in 22 bits, so its low 24 bits carry it exactly.
    logic signed [31:0] c5_w, centi_w;
    logic signed [23:0] v1_w;
    logic [20:0]        p0_w;
    logic signed [31:0] s4_fine_reg, s4_centi_reg;
    logic signed [23:0] s4_v1_reg;
    logic [20:0]        s4_p0_reg;

    assign c5_w    = (s3_fine_reg <<< 2) + s3_fine_reg + 32'sd128;
    assign centi_w = c5_w >>> 8;
    assign v1_w    = $signed(s3_fine_reg[23:0]) - FINE_OFFSET;
    assign p0_w    = PRESS_BASE - {1'b0, s3_adcp_reg};

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_fine_reg  <= s3_fine_reg;
            s4_centi_reg <= centi_w;
            s4_v1_reg    <= v1_w;
            s4_p0_reg    <= p0_w;
        end
    end

    // Stage 5: square of the offset variable and its products with P5 and P2.
    logic signed [47:0] s5_sq_reg;
    logic signed [39:0] s5_m5_reg, s5_m2_reg;
    logic signed [31:0] s5_fine_reg, s5_centi_reg;
    logic [20:0]        s5_p0_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_sq_reg    <= s4_v1_reg * s4_v1_reg;
            s5_m5_reg    <= s4_v1_reg * p5;
            s5_m2_reg    <= s4_v1_reg * p2;
            s5_fine_reg  <= s4_fine_reg;
            s5_centi_reg <= s4_centi_reg;
            s5_p0_reg    <= s4_p0_reg;
        end
    end

    // Stage 6: the square times P6 and P3, split into low and high partial products.
    // The square is non-negative and below 2^44.
    logic signed [48:0] s6_p6l_reg, s6_p3l_reg;
    logic signed [31:0] s6_p6h_reg, s6_p3h_reg;
    logic signed [39:0] s6_m5_reg, s6_m2_reg;
    logic signed [31:0] s6_fine_reg, s6_centi_reg;
    logic [20:0]        s6_p0_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_p6l_reg   <= $signed({1'b0, s5_sq_reg[31:0]}) * p6;
            s6_p6h_reg   <= $signed({1'b0, s5_sq_reg[46:32]}) * p6;
            s6_p3l_reg   <= $signed({1'b0, s5_sq_reg[31:0]}) * p3;
            s6_p3h_reg   <= $signed({1'b0, s5_sq_reg[46:32]}) * p3;
            s6_m5_reg    <= s5_m5_reg;
            s6_m2_reg    <= s5_m2_reg;
            s6_fine_reg  <= s5_fine_reg;
            s6_centi_reg <= s5_centi_reg;
            s6_p0_reg    <= s5_p0_reg;
        end
    end

    // Stage 7: recombine the partial products and align the linear terms.
    logic [63:0] q6_w, q3_w, t54_w, m2s_w;
    logic [63:0] s7_q6_reg, s7_q3_reg, s7_t54_reg, s7_m2s_reg;
    logic signed [31:0] s7_fine_reg, s7_centi_reg;
    logic [20:0] s7_p0_reg;

    assign q6_w  = {s6_p6h_reg, 32'b0} + {{15{s6_p6l_reg[48]}}, s6_p6l_reg};
    assign q3_w  = {s6_p3h_reg, 32'b0} + {{15{s6_p3l_reg[48]}}, s6_p3l_reg};
    assign t54_w = {{7{s6_m5_reg[39]}}, s6_m5_reg, 17'b0} + {{13{p4[15]}}, p4, 35'b0};
    assign m2s_w = {{12{s6_m2_reg[39]}}, s6_m2_reg, 12'b0};

    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_q6_reg    <= q6_w;
            s7_q3_reg    <= q3_w;
            s7_t54_reg   <= t54_w;
            s7_m2s_reg   <= m2s_w;
            s7_fine_reg  <= s6_fine_reg;
            s7_centi_reg <= s6_centi_reg;
            s7_p0_reg    <= s6_p0_reg;
        end
    end

    // Stage 8: second variable of the numerator and first variable of the divisor.
    logic signed [63:0] q3s_w;
    logic [63:0]        s8_v2_reg, s8_v1b_reg;
    logic signed [31:0] s8_fine_reg, s8_centi_reg;
    logic [20:0]        s8_p0_reg;

    assign q3s_w = $signed(s7_q3_reg) >>> 8;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s8_v2_reg    <= s7_q6_reg + s7_t54_reg;
            s8_v1b_reg   <= q3s_w + s7_m2s_reg;
            s8_fine_reg  <= s7_fine_reg;
            s8_centi_reg <= s7_centi_reg;
            s8_p0_reg    <= s7_p0_reg;
        end
    end

    // Stage 9: biased divisor term and the unscaled numerator.
    logic [63:0]        s9_w_reg, s9_n1_reg;
    logic signed [31:0] s9_fine_reg, s9_centi_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s9_w_reg     <= s8_v1b_reg + V1_BIAS;
            s9_n1_reg    <= {12'b0, s8_p0_reg, 31'b0} - s8_v2_reg;
            s9_fine_reg  <= s8_fine_reg;
            s9_centi_reg <= s8_centi_reg;
        end
    end

    // Stage 10: divisor term times P1 in two halves, numerator times 25.
    logic [63:0]        n25_w;
    logic [47:0]        s10_pwl_reg;
    logic [31:0]        s10_pwh_reg;
    logic [63:0]        s10_n25_reg;
    logic signed [31:0] s10_fine_reg, s10_centi_reg;

    assign n25_w = (s9_n1_reg << 4) + (s9_n1_reg << 3) + s9_n1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s10_pwl_reg   <= s9_w_reg[31:0] * p1;
            s10_pwh_reg   <= s9_w_reg[63:32] * {16'b0, p1};
            s10_n25_reg   <= n25_w;
            s10_fine_reg  <= s9_fine_reg;
            s10_centi_reg <= s9_centi_reg;
        end
    end

    // Stage 11: divisor after the 33-bit shift, numerator times a further 125.
    logic [63:0]        pw_w, n_w;
    logic [63:0]        s11_num_reg;
    logic [DEN_W-1:0]   s11_den_reg;
    logic signed [31:0] s11_fine_reg, s11_centi_reg;

    assign pw_w = {s10_pwh_reg, 32'b0} + {16'b0, s10_pwl_reg};
    assign n_w  = (s10_n25_reg << 7) - (s10_n25_reg << 2) + s10_n25_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s11_num_reg   <= n_w;
            s11_den_reg   <= pw_w[63:33];
            s11_fine_reg  <= s10_fine_reg;
            s11_centi_reg <= s10_centi_reg;
        end
    end

    // Stage 12: magnitudes and signs for the unsigned divider.
    brc_side_t        side_w;
    logic [63:0]      s12_num_reg;
    logic [DEN_W-1:0] s12_den_reg;
    brc_side_t        s12_side_reg;

    always_comb begin
        side_w.fine    = s11_fine_reg;
        side_w.centi   = s11_centi_reg;
        side_w.qneg    = s11_num_reg[63] ^ s11_den_reg[DEN_W-1];
        side_w.invalid = (s11_den_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s12_num_reg  <= s11_num_reg[63] ? (64'd0 - s11_num_reg) : s11_num_reg;
            s12_den_reg  <= s11_den_reg[DEN_W-1] ? ({DEN_W{1'b0}} - s11_den_reg) : s11_den_reg;
            s12_side_reg <= side_w;
        end
    end

    // Pressure divider.
    logic [DIV_W-1:0] div_quo;
    brc_side_t        div_side;

    brc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (adv),
        .in_valid  (pre_valid_reg[PRE_STAGES-1]),
        .in_num    (s12_num_reg),
        .in_den    (s12_den_reg),
        .in_side   (s12_side_reg),
        .out_valid (div_out_valid),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    // Back stage 1: signed pressure quotient.
    logic [63:0] d1_p_reg;
    brc_side_t   d1_side_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_p_reg    <= div_side.qneg ? (64'd0 - div_quo) : div_quo;
            d1_side_reg <= div_side;
        end
    end

    // Back stage 2: partial products of P9 and P8 with the pressure.
    logic signed [63:0] t_w;
    logic signed [48:0] d2_p9l_reg, d2_p8l_reg;
    logic [31:0]        d2_p9h_reg, d2_p8h_reg;
    logic [63:0]        d2_p_reg, d2_t_reg;
    brc_side_t          d2_side_reg;

    assign t_w = $signed(d1_p_reg) >>> 13;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d2_p9l_reg  <= $signed({1'b0, t_w[31:0]}) * p9;
            d2_p9h_reg  <= t_w[63:32] * {{16{p9[15]}}, p9};
            d2_p8l_reg  <= $signed({1'b0, d1_p_reg[31:0]}) * p8;
            d2_p8h_reg  <= d1_p_reg[63:32] * {{16{p8[15]}}, p8};
            d2_p_reg    <= d1_p_reg;
            d2_t_reg    <= t_w;
            d2_side_reg <= d1_side_reg;
        end
    end

    // Back stage 3: recombine, and finish the P8 term.
    logic [63:0]        p9t_w, p8p_w;
    logic signed [63:0] v2c_w;
    logic [63:0]        d3_p9t_reg, d3_t_reg, d3_p_reg, d3_v2c_reg;
    brc_side_t          d3_side_reg;

    assign p9t_w = {d2_p9h_reg, 32'b0} + {{15{d2_p9l_reg[48]}}, d2_p9l_reg};
    assign p8p_w = {d2_p8h_reg, 32'b0} + {{15{d2_p8l_reg[48]}}, d2_p8l_reg};
    assign v2c_w = $signed(p8p_w) >>> 19;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d3_p9t_reg  <= p9t_w;
            d3_t_reg    <= d2_t_reg;
            d3_p_reg    <= d2_p_reg;
            d3_v2c_reg  <= v2c_w;
            d3_side_reg <= d2_side_reg;
        end
    end

    // Back stage 4: low 64 bits of the second product, as three 32-bit partial products.
    logic [63:0] d4_ll_reg;
    logic [31:0] d4_lh_reg, d4_hl_reg;
    logic [63:0] d4_p_reg, d4_v2c_reg;
    brc_side_t   d4_side_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d4_ll_reg   <= d3_p9t_reg[31:0] * d3_t_reg[31:0];
            d4_lh_reg   <= d3_p9t_reg[31:0] * d3_t_reg[63:32];
            d4_hl_reg   <= d3_p9t_reg[63:32] * d3_t_reg[31:0];
            d4_p_reg    <= d3_p_reg;
            d4_v2c_reg  <= d3_v2c_reg;
            d4_side_reg <= d3_side_reg;
        end
    end

    // Back stage 5: sum the partial products and finish the P9 term.
    logic [31:0]        cross_w;
    logic [63:0]        prod_w;
    logic signed [63:0] v1c_w;
    logic [63:0]        d5_v1c_reg, d5_p_reg, d5_v2c_reg;
    brc_side_t          d5_side_reg;

    assign cross_w = d4_lh_reg + d4_hl_reg;
    assign prod_w  = d4_ll_reg + {cross_w, 32'b0};
    assign v1c_w   = $signed(prod_w) >>> 25;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d5_v1c_reg  <= v1c_w;
            d5_p_reg    <= d4_p_reg;
            d5_v2c_reg  <= d4_v2c_reg;
            d5_side_reg <= d4_side_reg;
        end
    end

    // Back stage 6: sum of pressure and both correction terms.
    logic [63:0] d6_s_reg;
    brc_side_t   d6_side_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d6_s_reg    <= d5_p_reg + d5_v1c_reg + d5_v2c_reg;
            d6_side_reg <= d5_side_reg;
        end
    end

    // Back stage 7: final offset, zero for an invalid result, saturation to 32 bits and the output register.
    logic signed [63:0] sh_w;
    logic [63:0]        res_w;
    logic [31:0]        pq_w;
    logic signed [31:0] d7_fine_reg, d7_centi_reg;
    logic [31:0]        d7_pq_reg;
    logic               d7_invalid_reg;

    assign sh_w  = $signed(d6_s_reg) >>> 8;
    assign res_w = sh_w + {{44{p7[15]}}, p7, 4'b0};

    always_comb begin
        priority if (d6_side_reg.invalid) begin
            pq_w = '0;
        end else if (res_w[63]) begin
            pq_w = '0;
        end else if (|res_w[62:32]) begin
            pq_w = '1;
        end else begin
            pq_w = res_w[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d7_fine_reg    <= d6_side_reg.fine;
            d7_centi_reg   <= d6_side_reg.centi;
            d7_pq_reg      <= pq_w;
            d7_invalid_reg <= d6_side_reg.invalid;
        end
    end

    assign m_valid             = post_valid_reg[POST_STAGES-1];
    assign m_fine_temperature  = d7_fine_reg;
    assign m_temperature_centi = d7_centi_reg;
    assign m_pressure_q24_8    = d7_pq_reg;
    assign m_pressure_invalid  = d7_invalid_reg;

endmodule

// ----- hw/rtl/brc_div.sv -----
module brc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        ce,
    input  logic                        in_valid,
    input  logic [brc_pkg::DIV_W-1:0]   in_num,
    input  logic [brc_pkg::DEN_W-1:0]   in_den,
    input  brc_pkg::brc_side_t          in_side,
    output logic                        out_valid,
    output logic [brc_pkg::DIV_W-1:0]   out_quo,
    output brc_pkg::brc_side_t          out_side
);
    import brc_pkg::*;

    logic               valid_reg [DIV_W];
    logic [DEN_W-1:0]   rem_reg   [DIV_W];
    logic [DIV_W-1:0]   work_reg  [DIV_W];
    logic [DEN_W-1:0]   den_reg   [DIV_W];
    brc_side_t          side_reg  [DIV_W];

    logic               st_valid [DIV_W];
    logic [DEN_W-1:0]   st_rem   [DIV_W];
    logic [DIV_W-1:0]   st_work  [DIV_W];
    logic [DEN_W-1:0]   st_den   [DIV_W];
    brc_side_t          st_side  [DIV_W];

    // Restoring division: each stage shifts in one dividend bit and decides one quotient bit.
    // The work word holds the remaining dividend bits on top and the quotient bits below.
    for (genvar i = 0; i < DIV_W; i++) begin : g_step
        logic [DEN_W:0]   trial;
        logic [DEN_W+1:0] diff;

        if (i == 0) begin : g_first
            assign st_valid[i] = in_valid;
            assign st_rem[i]   = '0;
            assign st_work[i]  = in_num;
            assign st_den[i]   = in_den;
            assign st_side[i]  = in_side;
        end else begin : g_next
            assign st_valid[i] = valid_reg[i-1];
            assign st_rem[i]   = rem_reg[i-1];
            assign st_work[i]  = work_reg[i-1];
            assign st_den[i]   = den_reg[i-1];
            assign st_side[i]  = side_reg[i-1];
        end

        assign trial = {st_rem[i], st_work[i][DIV_W-1]};
        assign diff  = {1'b0, trial} - {2'b0, st_den[i]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (ce) begin
                valid_reg[i] <= st_valid[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                if (!diff[DEN_W+1]) begin
                    rem_reg[i] <= diff[DEN_W-1:0];
                end else begin
                    rem_reg[i] <= trial[DEN_W-1:0];
                end
                work_reg[i] <= {st_work[i][DIV_W-2:0], ~diff[DEN_W+1]};
                den_reg[i]  <= st_den[i];
                side_reg[i] <= st_side[i];
            end
        end
    end

    assign out_valid = valid_reg[DIV_W-1];
    assign out_quo   = work_reg[DIV_W-1];
    assign out_side  = side_reg[DIV_W-1];

endmodule

// ----- hw/rtl/brc_checker.sv -----
module brc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_wr_en,
    input logic [brc_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input logic [brc_pkg::CAL_W-1:0]        cfg_wr_data,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [brc_pkg::RAW_W-1:0]        s_raw_temperature,
    input logic [brc_pkg::RAW_W-1:0]        s_raw_pressure,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic signed [brc_pkg::OUT_W-1:0] m_fine_temperature,
    input logic signed [brc_pkg::OUT_W-1:0] m_temperature_centi,
    input logic [brc_pkg::OUT_W-1:0]        m_pressure_q24_8,
    input logic                             m_pressure_invalid
);

    // After reset no result is offered.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // A zero divisor forces the pressure to zero.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pressure_invalid |-> m_pressure_q24_8 == '0)
        else $error("invalid pressure is not zero");

    // The centi temperature follows from the fine temperature of the same result.
    a_centi: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_temperature_centi ==
            ((m_fine_temperature * 32'sd5 + 32'sd128) >>> 8))
        else $error("centi temperature does not match fine temperature");

    // A held result keeps its fine temperature and pressure until the transfer.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fine_temperature)
            && $stable(m_pressure_q24_8))
        else $error("held result changed before transfer");

endmodule

bind barometer_raw_compensation_unit brc_checker u_brc_checker (.*);
